>>> src/olrc_pkg.sv
// Shared types, event codes and the per-event update functions of the light relay controller.
package olrc_pkg;

  // Event codes carried on the input tuser field.
  localparam logic [3:0] EV_MOTION  = 4'd1;
  localparam logic [3:0] EV_TIMER   = 4'd2;
  localparam logic [3:0] EV_LOCAL1  = 4'd3;
  localparam logic [3:0] EV_LOCAL2  = 4'd4;
  localparam logic [3:0] EV_REMOTE1 = 4'd5;
  localparam logic [3:0] EV_REMOTE2 = 4'd6;
  localparam logic [3:0] EV_AUTO    = 4'd7;
  localparam logic [3:0] EV_MANUAL  = 4'd8;

  // Relay report codes.
  localparam logic [1:0] REP_NONE = 2'd0;
  localparam logic [1:0] REP_ON   = 2'd1;
  localparam logic [1:0] REP_OFF  = 2'd2;

  // Payload widths on the stream ports.
  localparam int unsigned InTdataW  = 8;
  localparam int unsigned InTuserW  = 4;
  localparam int unsigned OutTdataW = 8;

  // Occupancy machine states.
  typedef enum logic [2:0] {
    OCC_OFF    = 3'b001,
    OCC_TIMED  = 3'b010,
    OCC_MANUAL = 3'b100
  } occ_state_e;

  // Switch mode machine states.
  typedef enum logic [2:0] {
    SW_OFF    = 3'b001,
    SW_BUTTON = 3'b010,
    SW_AUTO   = 3'b100
  } sw_state_e;

  // Complete controller state.
  typedef struct packed {
    occ_state_e occ;
    sw_state_e  sw1;
    sw_state_e  sw2;
    logic       relay1;
    logic       relay2;
  } ctl_state_t;

  // Result fields of one event, lowest field last in the struct.
  typedef struct packed {
    logic       auto_off_report;
    logic [1:0] report_two;
    logic [1:0] report_one;
    logic       timer_start;
    logic       relay2_on;
    logic       relay1_on;
  } ctl_result_t;

  // State and result travelling together through the update chain.
  typedef struct packed {
    ctl_state_t  st;
    ctl_result_t res;
  } ctl_step_t;

  // Occupancy machine: first stage of the per-event update.
  function automatic ctl_step_t occ_step(ctl_state_t s, logic [3:0] ev,
                                         logic bright, logic motion);
    ctl_step_t o;
    logic      leave_auto;
    o            = '0;
    o.st         = s;
    o.res        = '0;
    leave_auto   = (ev == EV_MANUAL) || (ev == EV_LOCAL1) || (ev == EV_LOCAL2);
    case (s.occ)
      OCC_OFF: begin
        if (ev == EV_MOTION) begin
          if (!bright) begin
            o.st.occ            = OCC_TIMED;
            o.st.relay1         = 1'b1;
            o.st.relay2         = 1'b1;
            o.res.report_one    = REP_ON;
            o.res.report_two    = REP_ON;
            o.res.timer_start   = 1'b1;
          end
        end else if (leave_auto) begin
          o.st.occ    = OCC_MANUAL;
          o.st.relay1 = 1'b0;
          o.st.relay2 = 1'b0;
        end
      end
      OCC_TIMED: begin
        if (ev == EV_TIMER && !motion) begin
          o.st.occ         = OCC_OFF;
          o.st.relay1      = 1'b0;
          o.st.relay2      = 1'b0;
          o.res.report_one = REP_OFF;
          o.res.report_two = REP_OFF;
        end else if (ev == EV_TIMER) begin
          o.res.timer_start = 1'b1;
        end else if (leave_auto) begin
          o.st.occ    = OCC_MANUAL;
          o.st.relay1 = 1'b0;
          o.st.relay2 = 1'b0;
        end
      end
      OCC_MANUAL: begin
        if (ev == EV_AUTO) begin
          o.st.occ = OCC_OFF;
        end
      end
      default: begin
      end
    endcase
    return o;
  endfunction

  // One switch mode machine; sel_two picks switch two and its buttons.
  function automatic ctl_step_t sw_step(ctl_step_t i, logic sel_two, logic [3:0] ev);
    ctl_step_t  o;
    sw_state_e  mode;
    logic       on_now;
    logic [3:0] ev_local;
    logic [3:0] ev_remote;
    logic       lvl;
    logic [1:0] rep;
    o         = i;
    mode      = sel_two ? i.st.sw2 : i.st.sw1;
    lvl       = sel_two ? i.st.relay2 : i.st.relay1;
    rep       = sel_two ? i.res.report_two : i.res.report_one;
    ev_local  = sel_two ? EV_LOCAL2 : EV_LOCAL1;
    ev_remote = sel_two ? EV_REMOTE2 : EV_REMOTE1;
    on_now    = (mode == SW_BUTTON);
    case (mode)
      SW_OFF, SW_BUTTON: begin
        if (ev == ev_local || ev == ev_remote) begin
          mode = on_now ? SW_OFF : SW_BUTTON;
          lvl  = !on_now;
          if (ev == ev_local) begin
            rep = on_now ? REP_OFF : REP_ON;
          end
        end else if (ev == EV_AUTO) begin
          // Return to automatic mode clears both switches and both relays.
          o.st.sw1    = SW_AUTO;
          o.st.sw2    = SW_AUTO;
          o.st.relay1 = 1'b0;
          o.st.relay2 = 1'b0;
          mode        = SW_AUTO;
          lvl         = 1'b0;
        end
      end
      SW_AUTO: begin
        if (ev == EV_MANUAL) begin
          o.st.sw1 = SW_OFF;
          o.st.sw2 = SW_OFF;
          mode     = SW_OFF;
        end else if (ev == ev_local) begin
          mode                  = SW_BUTTON;
          lvl                   = 1'b1;
          rep                   = REP_ON;
          o.res.auto_off_report = 1'b1;
        end else if (ev == ev_remote) begin
          mode = SW_BUTTON;
          lvl  = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (sel_two) begin
      o.st.sw2         = mode;
      o.st.relay2      = lvl;
      o.res.report_two = rep;
    end else begin
      o.st.sw1         = mode;
      o.st.relay1      = lvl;
      o.res.report_one = rep;
    end
    return o;
  endfunction

endpackage

>>> src/occupancy_light_relay_controller.sv
// Top level of the two-relay occupancy light controller.
//
// Each input transfer carries one event (tuser) with the ambient-light and
// motion levels (tdata); each event yields exactly one output transfer with
// the relay levels after the event, the timer restart pulse and the report
// codes. The block sustains one event per clock while the downstream side
// takes its results: an input register holds the event, and the whole state
// update (occupancy machine, then switch one, then switch two) is a short
// combinational path into the result register and the state registers.
// Output valid rises once the event has passed the input register and the
// result register. The result register decouples the two sides, so a new
// event is taken while a finished result still waits downstream.
module occupancy_light_relay_controller
  import olrc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // bit 0 ambient_bright, bit 1 motion_present, bits 7:2 zero
  input  logic [InTdataW-1:0]  s_axis_tdata,
  // bits 3:0 req_type
  input  logic [InTuserW-1:0]  s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // bit 0 relay1_on, bit 1 relay2_on, bit 2 timer_start, bits 4:3 report_one,
  // bits 6:5 report_two, bit 7 auto_off_report
  output logic [OutTdataW-1:0] m_axis_tdata
);

  logic        in_valid_q;
  logic [3:0]  ev_q;
  logic        bright_q;
  logic        motion_q;
  logic        out_valid_q;
  ctl_result_t res_q;
  ctl_result_t res_d;
  ctl_state_t  state_q;
  ctl_state_t  state_d;
  ctl_step_t   step_occ;
  ctl_step_t   step_sw1;
  ctl_step_t   step_sw2;
  logic        advance;

  // The held event moves into the result register when that register is empty or its result is taken.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      ev_q     <= s_axis_tuser;
      bright_q <= s_axis_tdata[0];
      motion_q <= s_axis_tdata[1];
    end
  end

  // State update: occupancy machine first, later relay writes win.
  always_comb begin
    step_occ = occ_step(state_q, ev_q, bright_q, motion_q);
    step_sw1 = sw_step(step_occ, 1'b0, ev_q);
    step_sw2 = sw_step(step_sw1, 1'b1, ev_q);
    state_d  = step_sw2.st;
    res_d    = step_sw2.res;
    res_d.relay1_on = step_sw2.st.relay1;
    res_d.relay2_on = step_sw2.st.relay2;
  end

  // Controller state and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '{occ: OCC_OFF, sw1: SW_AUTO, sw2: SW_AUTO,
                       relay1: 1'b0, relay2: 1'b0};
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        state_q <= state_d;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = res_q;

endmodule

>>> src/olrc_checker.sv
// Port-level checker for the light relay controller and its bind.
module olrc_checker
  import olrc_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [OutTdataW-1:0] m_axis_tdata
);

  // A stalled result keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Report codes never use the spare code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[4:3] != 2'd3) && (m_axis_tdata[6:5] != 2'd3))
    else $error("spare report code");

  // A report matches the relay level it describes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[4:3] != REP_ON || m_axis_tdata[0])
                   && (m_axis_tdata[4:3] != REP_OFF || !m_axis_tdata[0])
                   && (m_axis_tdata[6:5] != REP_ON || m_axis_tdata[1])
                   && (m_axis_tdata[6:5] != REP_OFF || !m_axis_tdata[1]))
    else $error("report disagrees with relay level");

  // An auto-off report always comes with an on report.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[7] |->
      (m_axis_tdata[4:3] == REP_ON) || (m_axis_tdata[6:5] == REP_ON))
    else $error("auto-off report without on report");

endmodule

bind occupancy_light_relay_controller olrc_checker u_olrc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

>>> sim/tb.sv
// Self-checking stream testbench for the two-relay occupancy light controller.
`timescale 1ns / 100ps

module tb;
  import olrc_pkg::*;

  // Event codes that the package does not name.
  localparam logic [3:0] EV_NONE       = 4'd0;
  localparam logic [3:0] EV_UNKNOWN_LO = 4'd9;
  localparam logic [3:0] EV_UNKNOWN_HI = 4'd15;

  localparam int CYCLE_LIMIT      = 500_000;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES     = 8;

  logic                 clk_i;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  // bit 0 ambient_bright, bit 1 motion_present, bits 7:2 zero
  logic [InTdataW-1:0]  s_axis_tdata  = '0;
  // bits 3:0 req_type
  logic [InTuserW-1:0]  s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // bit 0 relay1_on, bit 1 relay2_on, bit 2 timer_start, bits 4:3 report_one,
  // bits 6:5 report_two, bit 7 auto_off_report
  logic [OutTdataW-1:0] m_axis_tdata;

  occupancy_light_relay_controller DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Predicted controller state and the results still owed by the block.
  occ_state_e  occ_mode;
  sw_state_e   sw_mode [2];
  logic        relay_lvl [2];
  ctl_result_t expected_lights [$];

  int error_count   = 0;
  int cycle_count   = 0;
  int tx_idle_pct   = 0;
  int rx_idle_pct   = 0;
  int hold_off_reqs = 0;
  int hold_off_seen = 0;
  int rx_stall_left = 0;

  ctl_result_t got_lights;
  ctl_result_t want_lights;

  // Applies one event to the predicted state and returns the expected result.
  // The occupancy machine runs first, then switch one, then switch two; a later
  // relay write or report wins over an earlier one.
  function automatic ctl_result_t predict_lights(logic [3:0] ev, logic bright,
                                                 logic motion);
    ctl_result_t     r;
    logic [1:0][1:0] rep;
    logic            auto_off;
    logic            timer_restart;
    logic            leave_auto;
    logic            on_now;
    logic [3:0]      ev_local;
    logic [3:0]      ev_remote;
    int              k;
    rep[0]        = REP_NONE;
    rep[1]        = REP_NONE;
    auto_off      = 1'b0;
    timer_restart = 1'b0;
    leave_auto    = (ev == EV_MANUAL) || (ev == EV_LOCAL1) || (ev == EV_LOCAL2);

    // Occupancy machine.
    case (occ_mode)
      OCC_OFF: begin
        if (ev == EV_MOTION) begin
          if (!bright) begin
            occ_mode      = OCC_TIMED;
            relay_lvl[0]  = 1'b1;
            relay_lvl[1]  = 1'b1;
            rep[0]        = REP_ON;
            rep[1]        = REP_ON;
            timer_restart = 1'b1;
          end
        end else if (leave_auto) begin
          occ_mode     = OCC_MANUAL;
          relay_lvl[0] = 1'b0;
          relay_lvl[1] = 1'b0;
        end
      end
      OCC_TIMED: begin
        if (ev == EV_TIMER && !motion) begin
          occ_mode     = OCC_OFF;
          relay_lvl[0] = 1'b0;
          relay_lvl[1] = 1'b0;
          rep[0]       = REP_OFF;
          rep[1]       = REP_OFF;
        end else if (ev == EV_TIMER) begin
          timer_restart = 1'b1;
        end else if (leave_auto) begin
          occ_mode     = OCC_MANUAL;
          relay_lvl[0] = 1'b0;
          relay_lvl[1] = 1'b0;
        end
      end
      OCC_MANUAL: begin
        if (ev == EV_AUTO) begin
          occ_mode = OCC_OFF;
        end
      end
      default: begin
      end
    endcase

    // Switch machines; switch two sees what switch one changed.
    for (k = 0; k < 2; k++) begin
      ev_local  = (k == 0) ? EV_LOCAL1 : EV_LOCAL2;
      ev_remote = (k == 0) ? EV_REMOTE1 : EV_REMOTE2;
      case (sw_mode[k])
        SW_OFF, SW_BUTTON: begin
          on_now = (sw_mode[k] == SW_BUTTON);
          if (ev == ev_local || ev == ev_remote) begin
            sw_mode[k]   = on_now ? SW_OFF : SW_BUTTON;
            relay_lvl[k] = !on_now;
            if (ev == ev_local) begin
              rep[k] = on_now ? REP_OFF : REP_ON;
            end
          end else if (ev == EV_AUTO) begin
            sw_mode[0]   = SW_AUTO;
            sw_mode[1]   = SW_AUTO;
            relay_lvl[0] = 1'b0;
            relay_lvl[1] = 1'b0;
          end
        end
        SW_AUTO: begin
          if (ev == EV_MANUAL) begin
            sw_mode[0] = SW_OFF;
            sw_mode[1] = SW_OFF;
          end else if (ev == ev_local) begin
            sw_mode[k]   = SW_BUTTON;
            relay_lvl[k] = 1'b1;
            rep[k]       = REP_ON;
            auto_off     = 1'b1;
          end else if (ev == ev_remote) begin
            sw_mode[k]   = SW_BUTTON;
            relay_lvl[k] = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    r.relay1_on       = relay_lvl[0];
    r.relay2_on       = relay_lvl[1];
    r.timer_start     = timer_restart;
    r.report_one      = rep[0];
    r.report_two      = rep[1];
    r.auto_off_report = auto_off;
    return r;
  endfunction

  // Idle length: mostly short, now and then a long one.
  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 8) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d",
             cycle_count, what, got, want);
    error_count++;
  endtask

  // Offers one event and waits for its transfer; valid stays high afterwards so
  // that a following event can go out on the very next cycle.
  task automatic send_event(logic [3:0] ev, logic bright, logic motion);
    int gap;
    gap = ($urandom_range(0, 99) < tx_idle_pct) ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= InTdataW'({motion, bright});
    s_axis_tuser  <= ev;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_lights.push_back(predict_lights(ev, bright, motion));
  endtask

  // Weighted event mix: motion and timer events keep the occupancy machine
  // cycling, auto commands bring it back from manual often enough.
  task automatic send_random_event();
    int         pick;
    logic [3:0] ev;
    pick = $urandom_range(0, 99);
    if (pick < 22) begin
      ev = EV_MOTION;
    end else if (pick < 42) begin
      ev = EV_TIMER;
    end else if (pick < 50) begin
      ev = EV_LOCAL1;
    end else if (pick < 58) begin
      ev = EV_LOCAL2;
    end else if (pick < 64) begin
      ev = EV_REMOTE1;
    end else if (pick < 70) begin
      ev = EV_REMOTE2;
    end else if (pick < 82) begin
      ev = EV_AUTO;
    end else if (pick < 90) begin
      ev = EV_MANUAL;
    end else if (pick < 95) begin
      ev = EV_NONE;
    end else begin
      ev = 4'($urandom_range(EV_UNKNOWN_LO, EV_UNKNOWN_HI));
    end
    send_event(ev, $urandom_range(0, 2) == 0, 1'($urandom_range(0, 1)));
  endtask

  // Walks a set of events through the machine states, plus unknown codes.
  task automatic test_directed();
    tx_idle_pct = 30;
    rx_idle_pct = 10;
    send_event(EV_NONE, 1'b0, 1'b0);
    send_event(EV_TIMER, 1'b0, 1'b1);         // timer while off: no effect
    send_event(EV_MOTION, 1'b1, 1'b1);        // bright room: ignored
    send_event(EV_MOTION, 1'b0, 1'b1);        // dark room: lights on, timed
    send_event(EV_MOTION, 1'b0, 1'b0);
    send_event(EV_TIMER, 1'b1, 1'b1);         // still motion: timer restarts
    send_event(EV_TIMER, 1'b0, 1'b0);         // no motion: lights off
    send_event(EV_MOTION, 1'b0, 1'b1);
    send_event(EV_LOCAL1, 1'b1, 1'b0);        // leaves auto from timed
    send_event(EV_LOCAL1, 1'b0, 1'b0);        // toggles relay one off
    send_event(EV_REMOTE1, 1'b0, 1'b0);       // silent toggle on
    send_event(EV_REMOTE2, 1'b1, 1'b1);       // switch two leaves auto silently
    send_event(EV_LOCAL2, 1'b0, 1'b1);
    send_event(EV_AUTO, 1'b0, 1'b0);          // everything back to auto
    send_event(EV_MANUAL, 1'b1, 1'b0);        // both switches to off
    send_event(EV_REMOTE2, 1'b0, 1'b0);
    send_event(EV_AUTO, 1'b1, 1'b1);
    send_event(EV_MOTION, 1'b0, 1'b0);
    send_event(EV_MANUAL, 1'b0, 1'b1);        // manual command while timed
    send_event(EV_UNKNOWN_LO, 1'b1, 1'b1);
    send_event(EV_UNKNOWN_HI, 1'b1, 1'b0);
    send_event(EV_AUTO, 1'b0, 1'b0);
    send_event(EV_LOCAL2, 1'b0, 1'b0);        // local press from auto while off
    send_event(EV_UNKNOWN_LO + 4'd3, 1'b0, 1'b1);
    send_event(EV_AUTO, 1'b1, 1'b0);
  endtask

  task automatic test_random_events(int count, int tx_pct, int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    repeat (count) send_random_event();
  endtask

  // No idling on either side.
  task automatic test_back_to_back(int count);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (count) send_random_event();
  endtask

  // The receiver holds off for a long stretch while events keep coming, so the
  // block fills up and stalls its input.
  task automatic test_long_hold_off(int count);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_off_reqs++;
    repeat (count) send_random_event();
  endtask

  // Receiver: random stalls plus the requested long hold-off.
  always @(posedge clk_i) begin
    if (rx_stall_left > 0) begin
      rx_stall_left--;
      m_axis_tready <= 1'b0;
    end else if (hold_off_seen != hold_off_reqs) begin
      hold_off_seen++;
      rx_stall_left = LONG_HOLD_CYCLES - 1;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 99) < rx_idle_pct) begin
      rx_stall_left = pick_gap() - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_lights = ctl_result_t'(m_axis_tdata);
      if (expected_lights.size() == 0) begin
        report_mismatch("result with nothing pending", int'(m_axis_tdata), 0);
      end else begin
        want_lights = expected_lights.pop_front();
        if (got_lights.relay1_on !== want_lights.relay1_on)
          report_mismatch("relay1_on", int'(got_lights.relay1_on),
                          int'(want_lights.relay1_on));
        if (got_lights.relay2_on !== want_lights.relay2_on)
          report_mismatch("relay2_on", int'(got_lights.relay2_on),
                          int'(want_lights.relay2_on));
        if (got_lights.timer_start !== want_lights.timer_start)
          report_mismatch("timer_start", int'(got_lights.timer_start),
                          int'(want_lights.timer_start));
        if (got_lights.report_one !== want_lights.report_one)
          report_mismatch("report_one", int'(got_lights.report_one),
                          int'(want_lights.report_one));
        if (got_lights.report_two !== want_lights.report_two)
          report_mismatch("report_two", int'(got_lights.report_two),
                          int'(want_lights.report_two));
        if (got_lights.auto_off_report !== want_lights.auto_off_report)
          report_mismatch("auto_off_report", int'(got_lights.auto_off_report),
                          int'(want_lights.auto_off_report));
      end
    end
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    occ_mode     = OCC_OFF;
    sw_mode[0]   = SW_AUTO;
    sw_mode[1]   = SW_AUTO;
    relay_lvl[0] = 1'b0;
    relay_lvl[1] = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_events(500, 30, 15);
    test_back_to_back(300);
    test_long_hold_off(80);
    test_random_events(420, 15, 30);

    s_axis_tvalid <= 1'b0;
    while (expected_lights.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
